// ===== sv/assert_macros.svh =====
// Assertion helpers for the hasher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent implication check, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Concurrent next-cycle implication check, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256_pkg
// Types, round constants and helper functions for the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       final_item;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_part_0;
    logic [63:0] digest_part_1;
    logic [63:0] digest_part_2;
    logic [63:0] digest_part_3;
  } out_item_t;

  // Control from the top-level sequencer to the compression unit.
  typedef struct packed {
    logic start;
    logic load_iv;
  } cmp_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_OUT
  } state_e;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== sv/sha256_compress.sv =====
// ----------------------------------------------------------------------------
// sha256_compress
// 64-round compression over a block held in a word memory. One round per
// cycle; message schedule kept in a 16-word sliding window.
// ----------------------------------------------------------------------------
module sha256_compress (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sha256_pkg::cmp_ctrl_t ctrl_i,
  output logic [3:0]            rd_addr_o,
  input  logic [31:0]           rd_data_i,
  output logic                  done_o,
  output logic [255:0]          hash_o
);

  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic        fetch_q;
  logic [4:0]  fcnt_q;

  logic [31:0] wi, s0, s1, t1, t2, wnew;
  logic [5:0]  rnd;

  assign rnd = cnt_q[5:0];
  assign rd_addr_o = fcnt_q[3:0];

  always_comb begin
    s0   = sha256_pkg::rotr(w_q[1], 7) ^ sha256_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1   = sha256_pkg::rotr(w_q[14], 17) ^ sha256_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wnew = w_q[0] + s0 + w_q[9] + s1;
    wi   = w_q[0];
    t1 = v_q[7] + (sha256_pkg::rotr(v_q[4], 6) ^ sha256_pkg::rotr(v_q[4], 11)
         ^ sha256_pkg::rotr(v_q[4], 25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
         + sha256_pkg::RoundK[rnd] + wi;
    t2 = (sha256_pkg::rotr(v_q[0], 2) ^ sha256_pkg::rotr(v_q[0], 13)
         ^ sha256_pkg::rotr(v_q[0], 22))
         + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      fetch_q <= 1'b0;
      fcnt_q  <= '0;
      cnt_q   <= '0;
      done_o  <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::IV[i];
      for (int i = 0; i < 8; i++) v_q[i] <= '0;
      for (int i = 0; i < 16; i++) w_q[i] <= '0;
    end else begin
      done_o <= !busy_q && !fetch_q && (cnt_q == 7'd64);
      if (ctrl_i.load_iv) begin
        for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::IV[i];
      end
      if (ctrl_i.start) begin
        fetch_q <= 1'b1;
        fcnt_q  <= '0;
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      end else if (fetch_q) begin
        // read data arrives the cycle after its address
        fcnt_q <= fcnt_q + 5'd1;
        if (fcnt_q != 5'd0) begin
          for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          w_q[15] <= rd_data_i;
        end
        if (fcnt_q == 5'd16) begin
          fetch_q <= 1'b0;
          busy_q  <= 1'b1;
          cnt_q   <= '0;
        end
      end else if (busy_q) begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= wnew;
        v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4]; v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          busy_q <= 1'b0;
        end
      end
      if (!busy_q && !fetch_q && cnt_q == 7'd64) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
        cnt_q <= '0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) hash_o[255-32*i -: 32] = h_q[i];
  end

endmodule

// ===== sv/sha256_byte_stream_hasher_core.sv =====
// A byte without final is written straight into the block memory; each full block adds a
// compression (start, fetch, round and update steps), one round per cycle.
// A final item pads into the block memory one byte per cycle (up to 64 per block),
// then runs one or two compressions; the digest then moves to an output register.
// Input stalls outside idle. Reset: asynchronous active low; hash words return to
// initial values.
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_core
// Byte-stream SHA-256: collect bytes in a block memory, pad, compress, emit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sha256_byte_stream_hasher_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sha256_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sha256_pkg::out_item_t out_data_o
);

  // Block memory: 16 words of 32 bits, byte-writable, one read port.
  logic [31:0] mem [16];
  logic [31:0] mem_rd_q;
  logic [3:0]  rd_addr;
  logic        wr_en;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_byte;

  sha256_pkg::state_e state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic [63:0] total_q, total_d;
  logic        last_q, last_d;   // the running compression is the final one
  logic        done;
  logic [255:0] hash;
  sha256_pkg::cmp_ctrl_t ctrl;
  logic        in_xfer;
  logic        out_busy_q;

  // Padding bookkeeping: has the 0x80 marker been written yet, is a pad due.
  logic pad_pend_q, marker_q;
  logic start_q;

  assign in_xfer = in_valid_i && !in_stall_o;

  sha256_compress u_cmp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .rd_addr_o (rd_addr),
    .rd_data_i (mem_rd_q),
    .done_o    (done),
    .hash_o    (hash)
  );

  // Write one byte, big-endian within the word; register the read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_pos[5:2]][8*(3-wr_pos[1:0]) +: 8] <= wr_byte;
    end
    mem_rd_q <= mem[rd_addr];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    bits_d  = bits_q;
    total_d = total_q;
    last_d  = last_q;
    unique case (state_q)
      sha256_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_data_i.byte_valid) begin
            fill_d = fill_q + 6'd1;
            if (fill_q == 6'd63) begin
              bits_d  = bits_q + 64'd512;
              last_d  = 1'b0;
              state_d = sha256_pkg::ST_COMP;
              total_d = bits_q + 64'd512;
            end
          end
          if (in_data_i.final_item) begin
            // hold the bit count: a full block goes first, padding after
            total_d = bits_q + {55'd0, fill_d, 3'd0} + ((in_data_i.byte_valid
                      && fill_q == 6'd63) ? 64'd512 : 64'd0);
            if (!(in_data_i.byte_valid && fill_q == 6'd63)) begin
              state_d = sha256_pkg::ST_PAD;
            end
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        // one pad byte (0x80 when first) per cycle up to the length field, or to the block end
        fill_d = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          state_d = sha256_pkg::ST_COMP;
          last_d  = 1'b0;
        end else if (fill_q == sha256_pkg::LenPos - 6'd1) begin
          state_d = sha256_pkg::ST_LEN;
        end
      end
      sha256_pkg::ST_LEN: begin
        fill_d = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          state_d = sha256_pkg::ST_COMP;
          last_d  = 1'b1;
        end
      end
      sha256_pkg::ST_COMP: begin
        if (done) begin
          fill_d = '0;
          if (last_q) begin
            state_d = sha256_pkg::ST_OUT;
          end else if (total_q != bits_q || pad_pend_q) begin
            state_d = sha256_pkg::ST_PAD;
          end else begin
            state_d = sha256_pkg::ST_IDLE;
          end
        end
      end
      sha256_pkg::ST_OUT: begin
        // advance once the output register is free to take the digest
        if (!out_busy_q) begin
          state_d = sha256_pkg::ST_IDLE;
          fill_d  = '0;
          bits_d  = '0;
        end
      end
      default: state_d = sha256_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    wr_en   = 1'b0;
    wr_pos  = fill_q;
    wr_byte = in_data_i.data_byte;
    ctrl    = '0;
    in_stall_o = (state_q != sha256_pkg::ST_IDLE);
    unique case (state_q)
      sha256_pkg::ST_IDLE: wr_en = in_xfer && in_data_i.byte_valid;
      sha256_pkg::ST_PAD: begin
        wr_en   = 1'b1;
        wr_byte = marker_q ? 8'h00 : sha256_pkg::PadByte;
      end
      sha256_pkg::ST_LEN: begin
        wr_en   = 1'b1;
        wr_byte = total_q[8*(7-fill_q[2:0]) +: 8];
      end
      sha256_pkg::ST_COMP: ctrl.start = start_q;
      sha256_pkg::ST_OUT:  ctrl.load_iv = !out_busy_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sha256_pkg::ST_IDLE;
      fill_q     <= '0;
      bits_q     <= '0;
      total_q    <= '0;
      last_q     <= 1'b0;
      pad_pend_q <= 1'b0;
      marker_q   <= 1'b0;
      start_q    <= 1'b0;
      out_busy_q <= 1'b0;
      out_data_o <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      bits_q  <= bits_d;
      total_q <= total_d;
      last_q  <= last_d;
      start_q <= (state_d == sha256_pkg::ST_COMP) && (state_q != sha256_pkg::ST_COMP);
      if (state_q == sha256_pkg::ST_IDLE && in_xfer && in_data_i.final_item) begin
        pad_pend_q <= 1'b1;
        marker_q   <= 1'b0;
      end
      if (state_q == sha256_pkg::ST_PAD) begin
        marker_q <= 1'b1;
      end
      if (state_q == sha256_pkg::ST_COMP && done && last_q) begin
        pad_pend_q <= 1'b0;
      end
      // capture the digest while the hash words still hold it
      if (state_q == sha256_pkg::ST_OUT && !out_busy_q) begin
        out_busy_q <= 1'b1;
        out_data_o <= hash;
      end else if (out_valid_o && !out_stall_i) begin
        out_busy_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_busy_q;

  `ASSERT_IMPL(a_stall_busy, clk_i, rst_ni, state_q != sha256_pkg::ST_IDLE, in_stall_o)
  `ASSERT_NEXT(a_done_out, clk_i, rst_ni, state_q == sha256_pkg::ST_OUT && !out_busy_q,
               out_valid_o)
  `ASSERT_IMPL(a_len_fill, clk_i, rst_ni, state_q == sha256_pkg::ST_LEN,
               fill_q >= sha256_pkg::LenPos)

endmodule

// ===== tb/sv/tb_sha256_byte_stream_hasher_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sha256_byte_stream_hasher_core
// Self-checking bench: byte transfers go in, every digest is compared with a
// SHA-256 computed here or a known digest, under random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_sha256_byte_stream_hasher_core;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DirectedRows  = 12;
  localparam int unsigned RandomItems   = 1250;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  sha256_pkg::in_item_t  in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  sha256_pkg::out_item_t out_data_o;

  sha256_byte_stream_hasher_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state for the message being hashed.
  logic [31:0] hash_words [8];
  logic [7:0]  msg_block [64];
  int unsigned block_fill;
  logic [63:0] msg_bits;
  sha256_pkg::out_item_t digest_queue [$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_msg_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = hash_words[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundK[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_words[i] += v[i];
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_words[i] = sha256_pkg::IV[i];
    block_fill = 0;
    msg_bits   = '0;
  endtask

  // Advance the predictor by one accepted transfer; queue a digest on close.
  task automatic predict_digest(sha256_pkg::in_item_t item);
    logic [63:0] total;
    sha256_pkg::out_item_t dg;
    if (item.byte_valid) begin
      msg_block[block_fill] = item.data_byte;
      block_fill++;
      if (block_fill == 64) begin
        compress_msg_block();
        msg_bits += 64'd512;
        block_fill = 0;
      end
    end
    if (item.final_item) begin
      total = msg_bits + 64'(block_fill * 8);
      msg_block[block_fill] = sha256_pkg::PadByte;
      block_fill++;
      if (block_fill > 56) begin
        while (block_fill < 64) msg_block[block_fill++] = 8'h00;
        compress_msg_block();
        block_fill = 0;
      end
      while (block_fill < 56) msg_block[block_fill++] = 8'h00;
      for (int i = 0; i < 8; i++) msg_block[63-i] = total[8*i +: 8];
      compress_msg_block();
      dg.digest_part_0 = {hash_words[0], hash_words[1]};
      dg.digest_part_1 = {hash_words[2], hash_words[3]};
      dg.digest_part_2 = {hash_words[4], hash_words[5]};
      dg.digest_part_3 = {hash_words[6], hash_words[7]};
      digest_queue = {digest_queue, dg};
      restart_hash();
    end
  endtask

  // Directed rows: empty message, "abc", extremes, absent bytes, pad edges.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       final_item;
    int unsigned repeat_count;
  } dir_row_t;

  dir_row_t dir_rows [DirectedRows] = '{
    '{8'h00, 1'b0, 1'b1, 1},   // empty message: known digest
    '{8'h61, 1'b1, 1'b0, 1},   // "abc": known digest
    '{8'h62, 1'b1, 1'b0, 1},
    '{8'h63, 1'b1, 1'b1, 1},
    '{8'hff, 1'b1, 1'b0, 55},  // 55 bytes + close: pad fits one block
    '{8'h00, 1'b0, 1'b1, 1},
    '{8'h00, 1'b1, 1'b0, 56},  // 56 bytes: needs a second block
    '{8'h5a, 1'b0, 1'b0, 3},   // absent bytes change nothing
    '{8'h00, 1'b0, 1'b1, 1},
    '{8'ha5, 1'b1, 1'b0, 63},  // 64 bytes, closed by the last one
    '{8'h3c, 1'b1, 1'b1, 1},
    '{8'hff, 1'b1, 1'b1, 1}    // single 0xff byte
  };

  sha256_pkg::out_item_t known_digest [2] = '{
    '{64'he3b0c44298fc1c14, 64'h9afbf4c8996fb924,
      64'h27ae41e4649b934c, 64'ha495991b7852b855},
    '{64'hba7816bf8f01cfea, 64'h414140de5dae2223,
      64'hb00361a396177a9c, 64'hb410ff61f20015ad}
  };

  // Hold valid high across back-to-back items; drop it only for a gap.
  task automatic send_item(sha256_pkg::in_item_t item);
    int unsigned gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_digest(item);
    @(negedge clk_i);
  endtask

  // Drain side: draw a stall length per digest, check at acceptance.
  initial begin
    int unsigned hold;
    sha256_pkg::out_item_t exp_dg;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      hold = $urandom_range(0, 1) ? 0 : $urandom_range(0, 15);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (digest_queue.size() == 0) begin
        $display("%0t: unexpected digest, expected none, actual %h", $time, out_data_o);
        error_count++;
      end else begin
        exp_dg = digest_queue.pop_front();
        if (out_data_o.digest_part_0 !== exp_dg.digest_part_0) begin
          $display("%0t: digest_part_0 expected %h actual %h", $time,
                   exp_dg.digest_part_0, out_data_o.digest_part_0);
          error_count++;
        end
        if (out_data_o.digest_part_1 !== exp_dg.digest_part_1) begin
          $display("%0t: digest_part_1 expected %h actual %h", $time,
                   exp_dg.digest_part_1, out_data_o.digest_part_1);
          error_count++;
        end
        if (out_data_o.digest_part_2 !== exp_dg.digest_part_2) begin
          $display("%0t: digest_part_2 expected %h actual %h", $time,
                   exp_dg.digest_part_2, out_data_o.digest_part_2);
          error_count++;
        end
        if (out_data_o.digest_part_3 !== exp_dg.digest_part_3) begin
          $display("%0t: digest_part_3 expected %h actual %h", $time,
                   exp_dg.digest_part_3, out_data_o.digest_part_3);
          error_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("sha256_byte_stream_hasher_core test failed");
      $finish;
    end
  end

  initial begin
    sha256_pkg::in_item_t item;
    int unsigned msg_len;
    int unsigned sent;
    int unsigned wait_cycles;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    restart_hash();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed table; overwrite predictions with known digests.
    for (int r = 0; r < DirectedRows; r++) begin
      for (int k = 0; k < dir_rows[r].repeat_count; k++) begin
        item.data_byte  = dir_rows[r].data_byte;
        item.byte_valid = dir_rows[r].byte_valid;
        item.final_item = dir_rows[r].final_item;
        send_item(item);
        if (r == 0) digest_queue[digest_queue.size()-1] = known_digest[0];
        if (r == 3) digest_queue[digest_queue.size()-1] = known_digest[1];
      end
    end
    in_valid_i <= 1'b0;

    // Hold off until every digest has drained once.
    while (digest_queue.size() != 0) @(negedge clk_i);

    // Random messages: mostly short, a few long ones spanning several blocks.
    sent = 0;
    while (sent < RandomItems) begin
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                             : $urandom_range(0, 70);
      for (int k = 0; k <= msg_len; k++) begin
        item.data_byte  = 8'($urandom);
        item.byte_valid = ($urandom_range(0, 15) != 0);
        item.final_item = (k == msg_len);
        send_item(item);
        sent++;
      end
    end
    in_valid_i <= 1'b0;

    // Drain, then leave room for stray output.
    wait_cycles = 0;
    while (digest_queue.size() != 0 && wait_cycles < 5000) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    repeat (300) @(negedge clk_i);
    if (error_count == 0 && digest_queue.size() == 0)
      $display("sha256_byte_stream_hasher_core test passed");
    else
      $display("sha256_byte_stream_hasher_core test failed");
    $finish;
  end

endmodule
